// ===== hdl/raaf_pkg.sv =====
// shared types, widths and codes of the range array adaptive filter
package raaf_pkg;

  localparam int IDX_W = 3;
  localparam int MM_W = 16;
  localparam int GAIN_W = 17;
  localparam int EST_W = 32;
  localparam int CNT_W = 5;
  localparam int OUT_CNT_W = 4;
  localparam int SEN_W = 8;

  localparam int SENSOR_COUNT_DEF = 8;
  localparam int GAIN_FRAC_DEF = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] MODE_RANGE = 2'd0;
  localparam logic [1:0] MODE_SEED = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  localparam logic [1:0] CMD_SKIP = 2'd0;
  localparam logic [1:0] CMD_READING = 2'd1;
  localparam logic [1:0] CMD_SEED = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [MM_W-1:0] OOR_LIMIT = 16'd8190;
  localparam logic [MM_W-1:0] MM_MAX = 16'hFFFF;
  localparam logic [SEN_W-1:0] NONE_SENSOR = 8'hFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [IDX_W-1:0] idx;
    logic [MM_W-1:0] range_mm;
    logic oor;
  } cmd_t;

  typedef struct packed {
    logic [GAIN_W-1:0] slow_gain;
    logic [GAIN_W-1:0] fast_gain;
    logic [MM_W-1:0] jump_mm;
    logic [MM_W-1:0] obst_mm;
    logic [CNT_W-1:0] en;
  } cfg_t;

  typedef struct packed {
    logic accepted;
    logic [MM_W-1:0] filtered_mm;
    logic filter_ok;
    logic out_of_range;
    logic obstacle_here;
    logic [MM_W-1:0] nearest_mm;
    logic [SEN_W-1:0] nearest_sensor;
    logic [MM_W-1:0] farthest_mm;
    logic [OUT_CNT_W-1:0] obstacle_count;
    logic any_obstacle;
    logic [OUT_CNT_W-1:0] ready_count;
  } res_t;

endpackage

// ===== hdl/range_array_adaptive_filter_unit.sv =====
// each request passes load, multiply, step, apply, commit, scan and emit states in the back end;
//   a new request is taken only after the last result is emitted, and the scan
//   reads the per-sensor store one entry per cycle on its read port
// a two-entry command queue and a two-entry result queue decouple both sides
// reset (rst, synchronous, active high) restores the register defaults and
//   clears every sensor's flags and both queues; no clearing pass is needed
module range_array_adaptive_filter_unit import raaf_pkg::*; #(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
  parameter int GAIN_FRACTION_BITS = GAIN_FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           mode,
  input  logic [IDX_W-1:0]     sensor_sel,
  input  logic [MM_W-1:0]      range_mm,
  output logic                 empty,
  input  logic                 pop,
  output logic                 accepted,
  output logic [MM_W-1:0]      filtered_mm,
  output logic                 filter_ok,
  output logic                 out_of_range,
  output logic                 obstacle_here,
  output logic [MM_W-1:0]      nearest_mm,
  output logic [SEN_W-1:0]     nearest_sensor,
  output logic [MM_W-1:0]      farthest_mm,
  output logic [OUT_CNT_W-1:0] obstacle_count,
  output logic                 any_obstacle,
  output logic [OUT_CNT_W-1:0] ready_count
);

  localparam logic [2:0] REG_SLOW_GAIN = 3'd0;
  localparam logic [2:0] REG_FAST_GAIN = 3'd1;
  localparam logic [2:0] REG_JUMP = 3'd2;
  localparam logic [2:0] REG_OBST = 3'd3;
  localparam logic [2:0] REG_SENSORS = 3'd4;

  logic [GAIN_W-1:0] slow_gain;
  logic [GAIN_W-1:0] fast_gain;
  logic [MM_W-1:0] jump_threshold_mm;
  logic [MM_W-1:0] obstacle_limit_mm;
  logic [3:0] sensors_in_use;
  logic wr_req;
  cfg_t cfg;

  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_head;
  logic res_full;
  logic res_push;
  res_t res;
  logic [$bits(res_t)-1:0] res_bits;
  res_t head;

  assign pready = 1'b1;
  assign wr_req = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_gain <= 17'd6554;
      fast_gain <= 17'd32768;
      jump_threshold_mm <= 16'd50;
      obstacle_limit_mm <= 16'd200;
      sensors_in_use <= 4'd8;
    end else if (wr_req) begin
      case (paddr[4:2])
        REG_SLOW_GAIN: slow_gain <= pwdata[GAIN_W-1:0];
        REG_FAST_GAIN: fast_gain <= pwdata[GAIN_W-1:0];
        REG_JUMP: jump_threshold_mm <= pwdata[MM_W-1:0];
        REG_OBST: obstacle_limit_mm <= pwdata[MM_W-1:0];
        REG_SENSORS: sensors_in_use <= pwdata[3:0];
        default: slow_gain <= slow_gain;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SLOW_GAIN: prdata = 32'(slow_gain);
      REG_FAST_GAIN: prdata = 32'(fast_gain);
      REG_JUMP: prdata = 32'(jump_threshold_mm);
      REG_OBST: prdata = 32'(obstacle_limit_mm);
      REG_SENSORS: prdata = 32'(sensors_in_use);
      default: prdata = '0;
    endcase
  end

  always_comb begin
    cfg.slow_gain = slow_gain;
    cfg.fast_gain = fast_gain;
    cfg.jump_mm = jump_threshold_mm;
    cfg.obst_mm = obstacle_limit_mm;
    // enabled count saturates at the array size
    cfg.en = (CNT_W'(sensors_in_use) > CNT_W'(SENSOR_COUNT)) ?
             CNT_W'(SENSOR_COUNT) : CNT_W'(sensors_in_use);
  end

  raaf_front #(
    .QDEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .mode(mode),
    .sensor_sel(sensor_sel),
    .range_mm(range_mm),
    .en(cfg.en),
    .cmd_pop(cmd_pop),
    .cmd_empty(cmd_empty),
    .cmd_head(cmd_head)
  );

  raaf_back #(
    .SENSOR_COUNT(SENSOR_COUNT),
    .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .cmd_empty(cmd_empty),
    .cmd_head(cmd_head),
    .cmd_pop(cmd_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res(res)
  );

  raaf_queue #(
    .WIDTH($bits(res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(res_push),
    .wr_data(res),
    .full(res_full),
    .rd_en(pop),
    .rd_data(res_bits),
    .empty(empty)
  );

  assign head = res_t'(res_bits);
  assign accepted = head.accepted;
  assign filtered_mm = head.filtered_mm;
  assign filter_ok = head.filter_ok;
  assign out_of_range = head.out_of_range;
  assign obstacle_here = head.obstacle_here;
  assign nearest_mm = head.nearest_mm;
  assign nearest_sensor = head.nearest_sensor;
  assign farthest_mm = head.farthest_mm;
  assign obstacle_count = head.obstacle_count;
  assign any_obstacle = head.any_obstacle;
  assign ready_count = head.ready_count;

endmodule

// ===== hdl/raaf_queue.sv =====
// small register queue used for the command and result queues
module raaf_queue import raaf_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_wr;
  logic do_rd;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr);
    return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      case ({do_wr, do_rd})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== hdl/raaf_front.sv =====
// front end: takes requests, classifies them and queues commands
module raaf_front import raaf_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       mode,
  input  logic [IDX_W-1:0] sensor_sel,
  input  logic [MM_W-1:0]  range_mm,
  input  logic [CNT_W-1:0] en,
  input  logic             cmd_pop,
  output logic             cmd_empty,
  output cmd_t             cmd_head
);

  cmd_t cmd_in;
  logic in_range;
  logic [$bits(cmd_t)-1:0] head_bits;

  assign in_range = CNT_W'(sensor_sel) < en;

  always_comb begin
    cmd_in.idx = sensor_sel;
    cmd_in.range_mm = range_mm;
    case (mode)
      MODE_RANGE: cmd_in.kind = CMD_READING;
      MODE_SEED: cmd_in.kind = CMD_SEED;
      MODE_RESET: cmd_in.kind = CMD_CLEAR;
      default: cmd_in.kind = CMD_SKIP;
    endcase
    if (!in_range) begin
      cmd_in.kind = CMD_SKIP;
    end
    // reset requests and ignored requests never flag out of range
    cmd_in.oor = ((cmd_in.kind == CMD_READING) || (cmd_in.kind == CMD_SEED)) &&
                 (range_mm >= OOR_LIMIT);
  end

  raaf_queue #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QDEPTH)
  ) u_cmd_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(push),
    .wr_data(cmd_in),
    .full(full),
    .rd_en(cmd_pop),
    .rd_data(head_bits),
    .empty(cmd_empty)
  );

  assign cmd_head = cmd_t'(head_bits);

endmodule

// ===== hdl/raaf_back.sv =====
// back end: filter update sequencer, per-sensor store and array scan
module raaf_back import raaf_pkg::*; #(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
  parameter int GAIN_FRACTION_BITS = GAIN_FRAC_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic cmd_empty,
  input  cmd_t cmd_head,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam int IW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int SCW = $clog2(SENSOR_COUNT + 1);
  localparam int XW = (IW > IDX_W) ? IW : IDX_W;
  localparam int GFB = GAIN_FRACTION_BITS;
  localparam int GCW = (GFB + 1 > GAIN_W) ? GFB + 1 : GAIN_W;
  localparam int PROD_W = GAIN_W + EST_W;
  localparam int SUM_W = PROD_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MUL = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_SCAN = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  cmd_t cur;
  logic [XW-1:0] head_x;
  logic [XW-1:0] cur_x;
  logic [IW-1:0] head_a;
  logic [IW-1:0] cur_a;

  logic [EST_W-1:0] est_mem [SENSOR_COUNT];
  logic [MM_W-1:0] mm_mem [SENSOR_COUNT];
  logic [IW-1:0] rd_addr;
  logic [EST_W-1:0] rd_est;
  logic [MM_W-1:0] rd_mm;
  logic est_we;
  logic mm_we;

  logic [SENSOR_COUNT-1:0] primed;
  logic [SENSOR_COUNT-1:0] ready;
  logic [SENSOR_COUNT-1:0] seen;
  logic [SENSOR_COUNT-1:0] valid;
  logic [SENSOR_COUNT-1:0] written;

  logic up;
  logic [EST_W-1:0] mag;
  logic [GAIN_W-1:0] gain_sel;
  logic [MM_W-1:0] old_mm;
  logic [PROD_W-1:0] prod;
  logic [EST_W-1:0] step;
  logic [EST_W-1:0] est_new;
  logic [MM_W-1:0] cur_mm;

  logic [SCW-1:0] sc;
  logic p_vld;
  logic [IW-1:0] p_idx;
  logic [MM_W-1:0] near_mm;
  logic [SEN_W-1:0] near_s;
  logic [MM_W-1:0] far_mm;
  logic [CNT_W-1:0] obst_cnt;
  logic [CNT_W-1:0] ready_cnt;

  logic [EST_W-1:0] sample;
  logic up_c;
  logic [EST_W-1:0] mag_c;
  logic [MM_W-1:0] jump_eff;
  logic [EST_W-1:0] thr;
  logic [GAIN_W-1:0] g_raw;
  logic [GCW-1:0] one_w;
  logic [GAIN_W-1:0] g_c;
  logic [SUM_W-1:0] sum_c;
  logic [SUM_W-1:0] shifted;
  logic [EST_W-1:0] step_c;
  logic [EST_W-1:0] filt;
  logic [EST_W:0] rsum;
  logic [MM_W-1:0] mm_new;
  logic take_new;
  logic pe;
  logic pv;
  logic scan_issue;
  logic acc;

  assign head_x = XW'(cmd_head.idx);
  assign head_a = head_x[IW-1:0];
  assign cur_x = XW'(cur.idx);
  assign cur_a = cur_x[IW-1:0];
  assign acc = (cur.kind != CMD_SKIP);

  assign cmd_pop = (state == S_IDLE) && !cmd_empty;
  assign res_push = (state == S_EMIT) && !res_full;
  assign scan_issue = (sc < SCW'(SENSOR_COUNT));

  // jump size and gain selection
  assign sample = {cur.range_mm, 16'b0};
  assign up_c = (sample >= rd_est);
  assign mag_c = up_c ? sample - rd_est : rd_est - sample;
  assign jump_eff = (cfg.jump_mm == '0) ? 16'd1 : cfg.jump_mm;
  assign thr = {jump_eff, 16'b0};
  assign g_raw = (mag_c >= thr) ? cfg.fast_gain : cfg.slow_gain;
  assign one_w = GCW'(1) << GFB;
  assign g_c = (GCW'(g_raw) > one_w) ? one_w[GAIN_W-1:0] : g_raw;

  // rounded step, never past the target
  assign sum_c = SUM_W'(prod) + (SUM_W'(1) << (GFB - 1));
  assign shifted = sum_c >> GFB;
  assign step_c = (shifted > SUM_W'(mag)) ? mag : shifted[EST_W-1:0];

  assign filt = up ? rd_est + step : rd_est - step;

  assign rsum = {1'b0, est_new} + (EST_W + 1)'(32768);
  assign mm_new = rsum[EST_W] ? MM_MAX : rsum[EST_W-1:16];

  assign take_new = (cur.kind == CMD_READING) && ready[cur_a] && !cur.oor;

  always_comb begin
    est_we = 1'b0;
    mm_we = 1'b0;
    if (state == S_COMMIT) begin
      case (cur.kind)
        CMD_READING: begin
          est_we = take_new;
          mm_we = take_new;
        end
        CMD_SEED: est_we = 1'b1;
        default: begin
          est_we = 1'b0;
          mm_we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    case (state)
      S_IDLE: rd_addr = head_a;
      S_SCAN: rd_addr = scan_issue ? sc[IW-1:0] : cur_a;
      default: rd_addr = cur_a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (est_we) begin
      est_mem[cur_a] <= est_new;
    end
    if (mm_we) begin
      mm_mem[cur_a] <= mm_new;
    end
    rd_est <= est_mem[rd_addr];
    rd_mm <= mm_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!cmd_empty) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: state_next = S_MUL;
      S_MUL: state_next = S_STEP;
      S_STEP: state_next = S_APPLY;
      S_APPLY: state_next = S_COMMIT;
      S_COMMIT: state_next = S_SCAN;
      S_SCAN: begin
        if (!scan_issue) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!res_full) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      primed <= '0;
      ready <= '0;
      seen <= '0;
      valid <= '0;
      written <= '0;
      sc <= '0;
      p_vld <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_COMMIT: begin
          sc <= '0;
          p_vld <= 1'b0;
          case (cur.kind)
            CMD_READING: begin
              if (ready[cur_a]) begin
                seen[cur_a] <= 1'b1;
                if (cur.oor) begin
                  valid[cur_a] <= 1'b0;
                end else begin
                  primed[cur_a] <= 1'b1;
                  valid[cur_a] <= 1'b1;
                  written[cur_a] <= 1'b1;
                end
              end
            end
            CMD_SEED: begin
              primed[cur_a] <= 1'b1;
              ready[cur_a] <= 1'b1;
            end
            CMD_CLEAR: begin
              primed[cur_a] <= 1'b0;
              ready[cur_a] <= 1'b0;
              seen[cur_a] <= 1'b0;
              valid[cur_a] <= 1'b0;
              written[cur_a] <= 1'b0;
            end
            default: begin
              primed <= primed;
            end
          endcase
        end
        S_SCAN: begin
          p_vld <= scan_issue;
          if (scan_issue) begin
            sc <= sc + 1'b1;
          end
        end
        default: begin
          p_vld <= 1'b0;
        end
      endcase
    end
  end

  // scan entry whose memory data is now on rd_mm
  assign pe = p_vld && (CNT_W'(p_idx) < cfg.en);
  assign pv = pe && seen[p_idx] && valid[p_idx];

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!cmd_empty) begin
          cur <= cmd_head;
        end
      end
      S_LOAD: begin
        up <= up_c;
        mag <= mag_c;
        gain_sel <= g_c;
        old_mm <= written[cur_a] ? rd_mm : '0;
      end
      S_MUL: prod <= gain_sel * mag;
      S_STEP: step <= step_c;
      S_APPLY: begin
        est_new <= ((cur.kind == CMD_READING) && primed[cur_a]) ? filt : sample;
      end
      S_COMMIT: begin
        case (cur.kind)
          CMD_READING: cur_mm <= take_new ? mm_new : old_mm;
          CMD_SEED: cur_mm <= old_mm;
          default: cur_mm <= '0;
        endcase
        near_mm <= MM_MAX;
        near_s <= NONE_SENSOR;
        far_mm <= '0;
        obst_cnt <= '0;
        ready_cnt <= '0;
      end
      S_SCAN: begin
        p_idx <= sc[IW-1:0];
        if (pe && ready[p_idx]) begin
          ready_cnt <= ready_cnt + 1'b1;
        end
        if (pv) begin
          // strict compare keeps the lowest index on ties
          if (rd_mm < near_mm) begin
            near_mm <= rd_mm;
            near_s <= SEN_W'(p_idx);
          end
          if (rd_mm > far_mm) begin
            far_mm <= rd_mm;
          end
          if (rd_mm < cfg.obst_mm) begin
            obst_cnt <= obst_cnt + 1'b1;
          end
        end
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  always_comb begin
    res.accepted = acc;
    res.filtered_mm = cur_mm;
    res.filter_ok = acc && seen[cur_a] && valid[cur_a];
    res.out_of_range = cur.oor;
    res.obstacle_here = acc && valid[cur_a] && (cur_mm < cfg.obst_mm);
    res.nearest_mm = near_mm;
    res.nearest_sensor = near_s;
    res.farthest_mm = far_mm;
    res.obstacle_count = obst_cnt[OUT_CNT_W-1:0];
    res.any_obstacle = (obst_cnt != '0);
    res.ready_count = ready_cnt[OUT_CNT_W-1:0];
  end

  a_valid_primed: assert property (@(posedge clk) disable iff (rst)
    (valid & ~primed) == '0)
    else $error("valid sensor without primed estimate");

  a_valid_written: assert property (@(posedge clk) disable iff (rst)
    (valid & ~written) == '0)
    else $error("valid sensor without stored filtered value");

  // only a primed sensor has a stored estimate to step from
  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    ((state == S_APPLY) && (cur.kind == CMD_READING) && primed[cur_a]) |-> (step <= mag))
    else $error("filter step overshoots the reading");

  a_none_consistent: assert property (@(posedge clk) disable iff (rst)
    (res_push && (res.nearest_sensor == NONE_SENSOR)) |->
      ((res.nearest_mm == MM_MAX) && (res.farthest_mm == '0) && !res.any_obstacle))
    else $error("empty scan with nonempty summary");

  a_pop_then_load: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state == S_LOAD))
    else $error("command taken without starting its update");

endmodule
